[rtl/sprite_frame_animator_macros.svh]
// Assertion macros for the sprite frame animator.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SPRITE_FRAME_ANIMATOR_MACROS_SVH
`define SPRITE_FRAME_ANIMATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfa_pkg.sv]
// Shared widths, register indexes, command/status structs and helpers.
// Used by every module of the sprite frame animator.
`timescale 1ns / 1ps

package sfa_pkg;

  localparam int unsigned MAX_FRAMES = 1024;
  localparam int unsigned FRAME_W    = 10;
  localparam int unsigned COUNT_W    = 11;
  localparam int unsigned TILE_W     = 11;
  localparam int unsigned PIX_W      = 23;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned STEP_W     = 17;
  localparam int unsigned PHASE_W    = 24;
  localparam int unsigned PROD_W     = RATE_W + STEP_W;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned ENDS_W     = 8;
  localparam int unsigned DIV_W      = 11;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE           = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_ROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TILE_COL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TILE_ROW = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd7;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef struct packed {
    logic load;
    logic mul_rate;
    logic advance;
    logic div_start;
    logic div_sel_row;
    logic take_wrap;
    logic take_row;
    logic mul_x;
    logic mul_y;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_func;
    logic need_wrap;
    logic div_busy;
    logic out_free;
  } stat_t;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    r = c;
    if (c == '0) r = COUNT_W'(1);
    else if (c > COUNT_W'(MAX_FRAMES)) r = COUNT_W'(MAX_FRAMES);
    return r;
  endfunction

  function automatic logic [COUNT_W-1:0] eff_fpr(input logic [COUNT_W-1:0] f);
    return (f == '0) ? COUNT_W'(1) : f;
  endfunction

endpackage

[rtl/sfa_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on sfa_pkg for widths.
`timescale 1ns / 1ps

module sfa_div
  import sfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DIV_W-1:0] quot_o,
  output logic [DIV_W-1:0] rem_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     quot_q, quot_d;
  logic [DIV_W:0]       rem_q, rem_d;
  logic [DIV_W-1:0]     dsr_q, dsr_d;
  logic [DIV_W:0]       rem_sh;
  logic                 ge;

  assign rem_sh = {rem_q[DIV_W-1:0], quot_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      cnt_d  = DIV_CNT_W'(DIV_W);
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      quot_d = {quot_q[DIV_W-2:0], ge};
      rem_d  = ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[DIV_W-1:0];

endmodule

[rtl/sfa_dp.sv]
// Datapath: configuration registers, animation state, shared multiplier,
// divider and output register. Depends on sfa_pkg and sfa_div.
`timescale 1ns / 1ps

module sfa_dp
  import sfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  input  logic                  s_tuser_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  m_tready_i,
  output logic                  m_tvalid_o,
  output logic [OUT_DATA_W-1:0] m_tdata_o
);

  logic [RATE_W-1:0]  rate_q;
  logic               loop_q;
  logic [COUNT_W-1:0] fcount_q;
  logic [COUNT_W-1:0] fpr_q;
  logic [FRAME_W-1:0] tcol0_q;
  logic [FRAME_W-1:0] trow0_q;
  logic [SIZE_W-1:0]  fwidth_q;
  logic [SIZE_W-1:0]  fheight_q;

  logic [FRAME_W-1:0] frame_q;
  logic [PHASE_W-1:0] phase_q;
  logic               halted_q;
  logic [STEP_W-1:0]  tstep_q;
  logic [PROD_W-1:0]  prod_q;
  logic [DIV_W-1:0]   nf_q;
  logic               changed_q;
  logic [ENDS_W-1:0]  ends_q;
  logic [TILE_W-1:0]  col_q;
  logic [TILE_W-1:0]  row_q;
  logic [PIX_W-1:0]   px_q;

  logic                  m_tvalid_q;
  logic [OUT_DATA_W-1:0] m_tdata_q;

  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  fpr;
  logic [STEP_W-1:0]   in_tstep;
  logic [FRAME_W-1:0]  in_start;
  logic [PROD_W:0]     sum;
  logic [FRAME_W-1:0]  whole;
  logic [DIV_W-1:0]    nf;
  logic [FRAME_W-1:0]  last_frame;
  logic [RATE_W-1:0]   mul_a;
  logic [STEP_W-1:0]   mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic                div_busy;
  logic [DIV_W-1:0]    div_quot;
  logic [DIV_W-1:0]    div_rem;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;

  assign count      = eff_count(fcount_q);
  assign fpr        = eff_fpr(fpr_q);
  assign last_frame = FRAME_W'(count - COUNT_W'(1));
  assign in_tstep   = s_tdata_i[STEP_W-1:0];
  assign in_start   = s_tdata_i[STEP_W +: FRAME_W];

  assign sum   = {1'b0, prod_q} + (PROD_W + 1)'(phase_q);
  assign whole = sum[PHASE_W +: FRAME_W];
  assign nf    = {1'b0, frame_q} + {1'b0, whole};

  always_comb begin
    mul_a = halted_q ? '0 : rate_q;
    mul_b = tstep_q;
    if (cmd_i.mul_x) begin
      mul_a = RATE_W'(col_q);
      mul_b = STEP_W'(fwidth_q);
    end else if (cmd_i.mul_y) begin
      mul_a = RATE_W'(row_q);
      mul_b = STEP_W'(fheight_q);
    end
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign div_dividend = cmd_i.div_sel_row ? DIV_W'(frame_q) : nf_q;
  assign div_divisor  = cmd_i.div_sel_row ? fpr : count;

  sfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= '0;
      loop_q    <= 1'b1;
      fcount_q  <= COUNT_W'(1);
      fpr_q     <= COUNT_W'(1);
      tcol0_q   <= '0;
      trow0_q   <= '0;
      fwidth_q  <= SIZE_W'(1);
      fheight_q <= SIZE_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_RATE:           rate_q    <= cfg_data_i[RATE_W-1:0];
        CFG_LOOP_ENABLE:    loop_q    <= cfg_data_i[0];
        CFG_FRAME_COUNT:    fcount_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_FRAMES_PER_ROW: fpr_q     <= cfg_data_i[COUNT_W-1:0];
        CFG_FIRST_TILE_COL: tcol0_q   <= cfg_data_i[FRAME_W-1:0];
        CFG_FIRST_TILE_ROW: trow0_q   <= cfg_data_i[FRAME_W-1:0];
        CFG_FRAME_WIDTH:    fwidth_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT:   fheight_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      phase_q  <= '0;
      halted_q <= 1'b0;
    end else begin
      if (cmd_i.load && s_tuser_i == FUNC_RESTART) begin
        frame_q <= (COUNT_W'(in_start) >= count) ? last_frame : in_start;
      end
      if (cmd_i.advance) begin
        phase_q <= sum[PHASE_W-1:0];
        if (whole != '0) begin
          if (COUNT_W'(nf) >= count) begin
            if (!loop_q) begin
              frame_q  <= last_frame;
              halted_q <= 1'b1;
            end
          end else begin
            frame_q <= nf[FRAME_W-1:0];
          end
        end
      end else if (cfg_valid_i && cfg_index_i == CFG_RATE) begin
        halted_q <= 1'b0;
      end
      if (cmd_i.take_wrap) begin
        frame_q <= div_rem[FRAME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tstep_q   <= in_tstep;
      changed_q <= s_tuser_i == FUNC_RESTART;
      ends_q    <= '0;
    end
    if (cmd_i.mul_rate || cmd_i.mul_x || cmd_i.mul_y) begin
      prod_q <= mul_p;
    end
    if (cmd_i.advance && whole != '0) begin
      changed_q <= 1'b1;
      nf_q      <= nf;
      if (COUNT_W'(nf) >= count && !loop_q) begin
        ends_q <= ENDS_W'(1);
      end
    end
    if (cmd_i.take_wrap) begin
      ends_q <= (div_quot > DIV_W'(255)) ? '1 : div_quot[ENDS_W-1:0];
    end
    if (cmd_i.take_row) begin
      col_q <= TILE_W'(tcol0_q) + TILE_W'(div_rem);
      row_q <= TILE_W'(trow0_q) + TILE_W'(div_quot);
    end
    if (cmd_i.mul_y) begin
      px_q <= prod_q[PIX_W-1:0];
    end
    if (cmd_i.emit) begin
      m_tdata_q <= {halted_q, ends_q, changed_q, prod_q[PIX_W-1:0], px_q,
                    row_q, col_q, frame_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign stat_o.in_func   = s_tuser_i;
  assign stat_o.need_wrap = loop_q && whole != '0 && COUNT_W'(nf) >= count;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = !m_tvalid_q || m_tready_i;

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

endmodule

[rtl/sfa_ctrl.sv]
// Controller state machine sequencing one transaction through the datapath.
// Depends on sfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sprite_frame_animator_macros.svh"

module sfa_ctrl
  import sfa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_tvalid_i,
  output logic  s_tready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_ADV   = 4'd2;
  localparam logic [3:0] S_WDIV  = 4'd3;
  localparam logic [3:0] S_WWAIT = 4'd4;
  localparam logic [3:0] S_RDIV  = 4'd5;
  localparam logic [3:0] S_RWAIT = 4'd6;
  localparam logic [3:0] S_MULX  = 4'd7;
  localparam logic [3:0] S_MULY  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (stat_i.in_func == FUNC_RESTART) ? S_RDIV : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_rate = 1'b1;
        state_d        = S_ADV;
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = stat_i.need_wrap ? S_WDIV : S_RDIV;
      end
      S_WDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WWAIT;
      end
      S_WWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.take_wrap = 1'b1;
          state_d         = S_RDIV;
        end
      end
      S_RDIV: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_row = 1'b1;
        state_d           = S_RWAIT;
      end
      S_RWAIT: begin
        if (!stat_i.div_busy) begin
          cmd_o.take_row = 1'b1;
          state_d        = S_MULX;
        end
      end
      S_MULX: begin
        cmd_o.mul_x = 1'b1;
        state_d     = S_MULY;
      end
      S_MULY: begin
        cmd_o.mul_y = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready_o = state_q == S_IDLE;

  `SFA_ASSERT_NEXT(a_accept_leaves_idle, s_tvalid_i && s_tready_o, state_q != S_IDLE, "accepted transaction left controller idle")
  `SFA_ASSERT_NOW(a_idle_div_quiet, state_q == S_IDLE, !stat_i.div_busy, "divider busy while idle")
  `SFA_ASSERT_NEXT(a_div_start_busy, cmd_o.div_start, stat_i.div_busy, "divider did not start")
  `SFA_ASSERT_NOW(a_emit_room, cmd_o.emit, stat_i.out_free, "result emitted over a held result")

endmodule

[rtl/sprite_frame_animator.sv]
// Channel      Dir  Handshake                  Payload
// s (items)    in   s_tvalid_i / s_tready_o    s_tdata_i, s_tuser_i
// m (results)  out  m_tvalid_o / m_tready_i    m_tdata_o
// cfg (regs)   in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction at a time: a tick makes the phase step, moves the frame,
// divides (bit-serially) for the wrap if the frame wraps, then for the tile
// position, and forms both pixel products; a restart starts at the tile
// division. One shared multiplier forms the phase step and both pixel
// products. A finished result sits in the output register, so the next
// item is taken while it waits. Async active-low reset; cfg always ready.
`timescale 1ns / 1ps

module sprite_frame_animator
  import sfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  // [16:0] time_step, [26:17] start_frame
  input  logic [IN_DATA_W-1:0]  s_tdata_i,
  // [0] func
  input  logic                  s_tuser_i,
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  // [9:0] frame_index, [20:10] tile_col, [31:21] tile_row, [54:32] pixel_x,
  // [77:55] pixel_y, [78] frame_changed, [86:79] end_count, [87] stopped
  output logic [OUT_DATA_W-1:0] m_tdata_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  sfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sfa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tdata_o   (m_tdata_o)
  );

endmodule
